@@ rtl/gitt_pkg.sv @@
// types, codes and constants shared by the gate input toggle tester
package gitt_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int GATE_W       = 16;
  localparam int GATE_IDX_W   = $clog2(GATE_W);
  localparam int CHAN_W       = 5;
  localparam int REP_W        = 8;
  localparam int COUNT_W      = 5;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [CHAN_W-1:0] ACTIVE_RESET  = CHAN_W'(16);
  localparam logic [REP_W-1:0]  REPEATS_RESET = REP_W'(10);
  localparam logic [CHAN_W-1:0] MAX_CHAN      = CHAN_W'(MAX_CHANNELS);

  typedef enum logic [1:0] {
    KIND_CHECK   = 2'd0,
    KIND_SKIP    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_STUCK_HIGH = 2'd1,
    ERR_STUCK_LOW  = 2'd2,
    ERR_MULTI_HIGH = 2'd3
  } err_t;

  typedef enum logic {
    REG_ACTIVE_CHANNELS = 1'b0,
    REG_NUM_REPEATS     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] active_channels;
    logic [REP_W-1:0]  num_repeats;
  } cfg_t;

  typedef struct packed {
    logic               test_level;
    logic [CHAN_W-1:0]  current_channel;
    err_t               error_code;
    logic               channel_done;
    logic               still_running;
    logic [COUNT_W-1:0] gates_high_count;
  } result_t;

endpackage

@@ rtl/gitt_cfg.sv @@
// configuration register file behind the apb port
module gitt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gitt_pkg::ADDR_W-1:0] paddr,
  input  logic [gitt_pkg::DATA_W-1:0] pwdata,
  output logic [gitt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gitt_pkg::cfg_t             cfg
);
  import gitt_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_channels <= ACTIVE_RESET;
      cfg.num_repeats     <= REPEATS_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE_CHANNELS: cfg.active_channels <= pwdata[CHAN_W-1:0];
        REG_NUM_REPEATS:     cfg.num_repeats     <= pwdata[REP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACTIVE_CHANNELS: prdata = DATA_W'(cfg.active_channels);
      REG_NUM_REPEATS:     prdata = DATA_W'(cfg.num_repeats);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/gitt_core.sv @@
// test state registers and the per-item step logic
module gitt_core (
  input  logic                        clk,
  input  logic                        rst,
  input  gitt_pkg::cfg_t              cfg,
  input  logic                        advance,
  input  gitt_pkg::kind_t             kind,
  input  logic [gitt_pkg::GATE_W-1:0] gate_levels,
  input  logic                        jack_ready,
  output gitt_pkg::result_t           result_next
);
  import gitt_pkg::*;

  logic [CHAN_W-1:0] channel_index, channel_index_next;
  logic [REP_W-1:0]  step_count, step_count_next;
  err_t              error_state, error_state_next;
  logic              drive_level, drive_level_next;

  logic [CHAN_W-1:0]  lim;
  logic [GATE_W-1:0]  masked;
  logic [COUNT_W-1:0] nhigh;
  logic               in_range;
  logic               gate;
  logic               done;

  assign lim      = (cfg.active_channels < MAX_CHAN) ? cfg.active_channels : MAX_CHAN;
  assign in_range = channel_index < lim;

  always_comb begin
    for (int i = 0; i < GATE_W; i++) begin
      masked[i] = gate_levels[i] && (CHAN_W'(i) < lim);
    end
  end

  assign nhigh = COUNT_W'($countones(masked));
  assign gate  = (channel_index < CHAN_W'(GATE_W)) ?
                 gate_levels[channel_index[GATE_IDX_W-1:0]] : 1'b0;

  always_comb begin
    channel_index_next = channel_index;
    step_count_next    = step_count;
    error_state_next   = error_state;
    drive_level_next   = drive_level;
    done               = 1'b0;
    case (kind)
      KIND_CHECK: begin
        if (in_range && !(step_count == REP_W'(1) && !jack_ready)) begin
          if (!step_count[0]) begin
            if (!gate) begin
              step_count_next  = step_count + REP_W'(1);
              drive_level_next = 1'b1;
            end else if (step_count >= REP_W'(2)) begin
              error_state_next = ERR_STUCK_HIGH;
            end
          end else begin
            if (gate) begin
              step_count_next  = step_count + REP_W'(1);
              drive_level_next = 1'b0;
            end else if (step_count >= REP_W'(2)) begin
              step_count_next  = REP_W'(1);
              error_state_next = ERR_STUCK_LOW;
            end
          end
          if (step_count_next >= cfg.num_repeats) begin
            error_state_next   = ERR_NONE;
            channel_index_next = channel_index + CHAN_W'(1);
            step_count_next    = '0;
            drive_level_next   = 1'b0;
            done               = 1'b1;
          end
        end
        if (nhigh > COUNT_W'(1)) begin
          error_state_next = ERR_MULTI_HIGH;
        end
      end
      KIND_SKIP: begin
        if (in_range) begin
          channel_index_next = channel_index + CHAN_W'(1);
        end
      end
      KIND_CLEAR: begin
        error_state_next = ERR_NONE;
      end
      KIND_RESTART: begin
        channel_index_next = '0;
        step_count_next    = '0;
        error_state_next   = ERR_NONE;
        drive_level_next   = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_next.test_level       = drive_level_next;
    result_next.current_channel  = channel_index_next;
    result_next.error_code       = error_state_next;
    result_next.channel_done     = done;
    result_next.still_running    = channel_index_next < lim;
    result_next.gates_high_count = nhigh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      step_count    <= '0;
      error_state   <= ERR_NONE;
      drive_level   <= 1'b0;
    end else if (advance) begin
      channel_index <= channel_index_next;
      step_count    <= step_count_next;
      error_state   <= error_state_next;
      drive_level   <= drive_level_next;
    end
  end

endmodule

@@ rtl/gate_input_toggle_tester.sv @@
// top level of the gate input toggle tester: input register, step logic, result register
//
//   channel | handshake                   | payload
//   item    | item_valid / item_ready     | kind, gate_levels, jack_ready
//   result  | result_valid / result_ready | test_level, current_channel, error_code,
//           |                             | channel_done, still_running, gates_high_count
//   config  | psel / penable / pwrite     | paddr, pwdata, prdata, pready
//
// one item per cycle while results are taken; an item's result becomes valid once it has passed
// the input register and then the result register fed by the step logic
// a result held by result_ready stalls the input register; item_ready drops once both are full
// synchronous reset clears the test state, the valid flags and the registers to defaults
module gate_input_toggle_tester (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [1:0]                  kind,
  input  logic [gitt_pkg::GATE_W-1:0] gate_levels,
  input  logic                        jack_ready,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        test_level,
  output logic [gitt_pkg::CHAN_W-1:0] current_channel,
  output logic [1:0]                  error_code,
  output logic                        channel_done,
  output logic                        still_running,
  output logic [gitt_pkg::COUNT_W-1:0] gates_high_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gitt_pkg::ADDR_W-1:0] paddr,
  input  logic [gitt_pkg::DATA_W-1:0] pwdata,
  output logic [gitt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import gitt_pkg::*;

  cfg_t              cfg;
  logic              held_valid;
  kind_t             held_kind;
  logic [GATE_W-1:0] held_levels;
  logic              held_ready;
  logic              advance;
  result_t           result_next;
  result_t           result;

  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  gitt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gitt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .kind        (held_kind),
    .gate_levels (held_levels),
    .jack_ready  (held_ready),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      held_kind   <= kind_t'(kind);
      held_levels <= gate_levels;
      held_ready  <= jack_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign test_level       = result.test_level;
  assign current_channel  = result.current_channel;
  assign error_code       = result.error_code;
  assign channel_done     = result.channel_done;
  assign still_running    = result.still_running;
  assign gates_high_count = result.gates_high_count;

endmodule

@@ tb/sv/tb_gate_input_toggle_tester.sv @@
// self-checking testbench for the gate input toggle tester: directed table, then random phases
module tb_gate_input_toggle_tester;
  import gitt_pkg::*;

  localparam int unsigned LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASE_ACTIVE [PHASES] = '{3, 1, 31, 0, 16, 5, 8, 2, 17};
  localparam int PHASE_REPEATS [PHASES] = '{4, 1, 2, 5, 255, 0, 3, 7, 1};

  typedef struct packed {
    kind_t        k;
    logic [15:0]  gates;
    logic         jack;
    logic         typed;
    result_t      want;
  } dir_row_t;

  localparam int DIR_N = 16;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{KIND_CHECK,   16'h0000, 1'b0, 1'b1, '{1'b1, 5'd0, ERR_NONE, 1'b0, 1'b1, 5'd0}},
    '{KIND_CHECK,   16'h0000, 1'b0, 1'b1, '{1'b1, 5'd0, ERR_NONE, 1'b0, 1'b1, 5'd0}},
    '{KIND_CHECK,   16'h0001, 1'b1, 1'b0, '0},
    '{KIND_CHECK,   16'h0001, 1'b1, 1'b0, '0},
    '{KIND_CLEAR,   16'h0001, 1'b1, 1'b0, '0},
    '{KIND_CHECK,   16'h0000, 1'b1, 1'b0, '0},
    '{KIND_CHECK,   16'h0000, 1'b1, 1'b0, '0},
    '{KIND_CHECK,   16'hFFFF, 1'b1, 1'b1, '{1'b0, 5'd0, ERR_MULTI_HIGH, 1'b0, 1'b1, 5'd16}},
    '{KIND_SKIP,    16'hFFFF, 1'b0, 1'b0, '0},
    '{KIND_CLEAR,   16'h0000, 1'b0, 1'b0, '0},
    '{KIND_CHECK,   16'h0002, 1'b1, 1'b0, '0},
    '{KIND_CHECK,   16'h0000, 1'b1, 1'b0, '0},
    '{KIND_RESTART, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 5'd0, ERR_NONE, 1'b0, 1'b1, 5'd16}},
    '{KIND_RESTART, 16'h0000, 1'b0, 1'b1, '{1'b0, 5'd0, ERR_NONE, 1'b0, 1'b1, 5'd0}},
    '{KIND_CHECK,   16'h8000, 1'b0, 1'b0, '0},
    '{KIND_SKIP,    16'h7FFF, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_ready;
  logic [1:0] kind;
  logic [GATE_W-1:0] gate_levels;
  logic jack_ready;
  logic result_valid;
  logic result_ready;
  logic test_level;
  logic [CHAN_W-1:0] current_channel;
  logic [1:0] error_code;
  logic channel_done;
  logic still_running;
  logic [COUNT_W-1:0] gates_high_count;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  gate_input_toggle_tester DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .kind(kind), .gate_levels(gate_levels), .jack_ready(jack_ready),
    .result_valid(result_valid), .result_ready(result_ready),
    .test_level(test_level), .current_channel(current_channel), .error_code(error_code),
    .channel_done(channel_done), .still_running(still_running),
    .gates_high_count(gates_high_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // tester state as it should be after every accepted item
  logic [CHAN_W-1:0] chan_idx;
  logic [REP_W-1:0]  step_cnt;
  err_t              err_st;
  logic              drive_lvl;
  logic [CHAN_W-1:0] cfg_active;
  logic [REP_W-1:0]  cfg_repeats;

  result_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  function automatic logic [CHAN_W-1:0] eff_count();
    return (cfg_active < CHAN_W'(MAX_CHANNELS)) ? cfg_active : CHAN_W'(MAX_CHANNELS);
  endfunction

  task automatic step_tester(input kind_t k, input logic [15:0] g, input logic j,
                             output result_t r);
    logic [CHAN_W-1:0] eff;
    logic [COUNT_W-1:0] nhigh;
    logic gb;
    logic done;
    eff = eff_count();
    nhigh = '0;
    done = 1'b0;
    for (int i = 0; i < GATE_W; i++) begin
      if (i < eff) nhigh += g[i];
    end
    case (k)
      KIND_CHECK: begin
        if (chan_idx < eff && !(step_cnt == 8'd1 && !j)) begin
          gb = (chan_idx < 16) ? g[chan_idx[3:0]] : 1'b0;
          if (!step_cnt[0]) begin
            if (!gb) begin
              step_cnt = step_cnt + 8'd1;
              drive_lvl = 1'b1;
            end else if (step_cnt >= 8'd2) begin
              err_st = ERR_STUCK_HIGH;
            end
          end else begin
            if (gb) begin
              step_cnt = step_cnt + 8'd1;
              drive_lvl = 1'b0;
            end else if (step_cnt >= 8'd2) begin
              step_cnt = 8'd1;
              err_st = ERR_STUCK_LOW;
            end
          end
          if (step_cnt >= cfg_repeats) begin
            err_st = ERR_NONE;
            chan_idx = chan_idx + 5'd1;
            step_cnt = '0;
            drive_lvl = 1'b0;
            done = 1'b1;
          end
        end
        if (nhigh > 1) err_st = ERR_MULTI_HIGH;
      end
      KIND_SKIP: begin
        if (chan_idx < eff) chan_idx = chan_idx + 5'd1;
      end
      KIND_CLEAR: begin
        err_st = ERR_NONE;
      end
      default: begin
        chan_idx = '0;
        step_cnt = '0;
        err_st = ERR_NONE;
        drive_lvl = 1'b0;
      end
    endcase
    r.test_level = drive_lvl;
    r.current_channel = chan_idx;
    r.error_code = err_st;
    r.channel_done = done;
    r.still_running = (chan_idx < eff);
    r.gates_high_count = nhigh;
  endtask

  task automatic offer_item(input kind_t k, input logic [15:0] g, input logic j,
                            input logic typed, input result_t typed_r);
    result_t r;
    item_valid <= 1'b1;
    kind <= k;
    gate_levels <= g;
    jack_ready <= j;
    do @(posedge clk); while (!item_ready);
    step_tester(k, g, j, r);
    pending_results.push_back(typed ? typed_r : r);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    logic [15:0] g;
    logic j;
    kind_t k;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    j = ($urandom_range(0, 9) != 0);
    k = KIND_CHECK;
    g = '0;
    if (pick < 70) begin
      // gate follows the level the tester expects, sometimes with a stray high gate
      if (chan_idx < 16) g[chan_idx[3:0]] = step_cnt[0];
      if ($urandom_range(0, 3) == 0) g[$urandom_range(0, 15)] = 1'b1;
    end else begin
      g = 16'($urandom);
      j = 1'($urandom);
      if (pick >= 97) k = KIND_RESTART;
      else if (pick >= 92) k = KIND_CLEAR;
      else if (pick >= 85) k = KIND_SKIP;
    end
    if (chan_idx >= eff_count() && $urandom_range(0, 4) == 0) k = KIND_RESTART;
    offer_item(k, g, j, 1'b0, '0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_CHANNELS: cfg_active = val[CHAN_W-1:0];
      default: cfg_repeats = val[REP_W-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 30;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left != 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && result_valid && result_ready) begin
      got.test_level = test_level;
      got.current_channel = current_channel;
      got.error_code = err_t'(error_code);
      got.channel_done = channel_done;
      got.still_running = still_running;
      got.gates_high_count = gates_high_count;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: level %0b/%0b chan %0d/%0d err %0d/%0d",
                     want.test_level, got.test_level, want.current_channel,
                     got.current_channel, want.error_code, got.error_code);
            $display("  done %0b/%0b running %0b/%0b high %0d/%0d (expected/actual)",
                     want.channel_done, got.channel_done, want.still_running,
                     got.still_running, want.gates_high_count, got.gates_high_count);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    kind = KIND_CHECK;
    gate_levels = '0;
    jack_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    chan_idx = '0;
    step_cnt = '0;
    err_st = ERR_NONE;
    drive_lvl = 1'b0;
    cfg_active = ACTIVE_RESET;
    cfg_repeats = REPEATS_RESET;
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      offer_item(DIR_ROWS[i].k, DIR_ROWS[i].gates, DIR_ROWS[i].jack,
                 DIR_ROWS[i].typed, DIR_ROWS[i].want);
      maybe_idle();
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_ACTIVE_CHANNELS, DATA_W'(PHASE_ACTIVE[p]));
        write_reg(REG_NUM_REPEATS, DATA_W'(PHASE_REPEATS[p]));
      end else begin
        write_reg(REG_NUM_REPEATS, DATA_W'(PHASE_REPEATS[p]));
        write_reg(REG_ACTIVE_CHANNELS, DATA_W'(PHASE_ACTIVE[p]));
      end
      calm = (p == PHASES - 1);
      tx_idle_pct = calm ? 0 : pick_pct();
      rx_stall_pct = calm ? 0 : pick_pct();
      if (p == 2) hold_request = 1'b1;
      if ($urandom_range(0, 1)) offer_item(KIND_RESTART, 16'($urandom), 1'($urandom), 1'b0, '0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_item();
        maybe_idle();
      end
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
